@@ rtl/pcpa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types, register indexes, status codes and the microcode program
// of the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

    // Default sizing
    localparam int DEF_CPU_COUNT  = 8;
    localparam int DEF_PAGE_BYTES = 4096;
    localparam int DEF_PAGE_COUNT = 32768;

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEAL_LIMIT = 2'd2;

    localparam logic [31:0] RST_REGION_LOW  = 32'd0;
    localparam logic [31:0] RST_REGION_HIGH = 32'd134217728;
    localparam logic [7:0]  RST_STEAL_LIMIT = 8'd10;

    // Commands
    localparam logic CMD_FREE  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FREED     = 2'd0,
        ST_ALLOCATED = 2'd1,
        ST_NONE      = 2'd2,
        ST_BAD       = 2'd3
    } status_t;

    // Request and result payloads
    typedef struct packed {
        logic        command;
        logic [2:0]  cpu_id;
        logic [31:0] page_address;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_address;
    } result_t;

    // Microcode
    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t U_IDLE   = 4'd0;
    localparam upc_t U_DEC    = 4'd1;
    localparam upc_t U_FCHK   = 4'd2;
    localparam upc_t U_FPUSH  = 4'd3;
    localparam upc_t U_ACHK   = 4'd4;
    localparam upc_t U_ATEST  = 4'd5;
    localparam upc_t U_STEST  = 4'd6;
    localparam upc_t U_SSKIP  = 4'd7;
    localparam upc_t U_SMOVE  = 4'd8;
    localparam upc_t U_POP    = 4'd9;
    localparam upc_t U_POPW   = 4'd10;
    localparam upc_t U_NEXT   = 4'd11;
    localparam upc_t U_BAD    = 4'd12;
    localparam upc_t U_NONE   = 4'd13;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOSTART,
        C_ALLOC,
        C_BADFREE,
        C_CPUBAD,
        C_TOP_VALID,
        C_TOP_EMPTY,
        C_STEAL_DONE,
        C_OTHER_SKIP
    } cond_sel_t;

    typedef enum logic [1:0] {
        HR_NONE,
        HR_CPU,
        HR_OTHER
    } hd_rd_t;

    typedef enum logic [1:0] {
        HW_NONE,
        HW_FREE,
        HW_STEAL,
        HW_POP
    } hd_wr_t;

    typedef enum logic [1:0] {
        LR_NONE,
        LR_HEAD,
        LR_TOP
    } ln_rd_t;

    typedef enum logic [1:0] {
        LW_NONE,
        LW_FREE,
        LW_STEAL
    } ln_wr_t;

    typedef struct packed {
        cond_sel_t cond;
        upc_t      target;
        hd_rd_t    hd_rd;
        hd_wr_t    hd_wr;
        ln_rd_t    ln_rd;
        ln_wr_t    ln_wr;
        logic      alloc_init;
        logic      steal_push;
        logic      other_inc;
        logic      emit;
        status_t   emit_status;
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic alloc;
        logic bad_free;
        logic cpu_bad;
        logic top_valid;
        logic steal_done;
        logic other_skip;
    } flags_t;

    function automatic ctrl_t uc_rom(input upc_t addr);
        ctrl_t w;
        w.cond        = C_NEVER;
        w.target      = U_IDLE;
        w.hd_rd       = HR_NONE;
        w.hd_wr       = HW_NONE;
        w.ln_rd       = LR_NONE;
        w.ln_wr       = LW_NONE;
        w.alloc_init  = 1'b0;
        w.steal_push  = 1'b0;
        w.other_inc   = 1'b0;
        w.emit        = 1'b0;
        w.emit_status = ST_FREED;
        case (addr)
            U_IDLE:
            begin
                w.cond   = C_NOSTART;
                w.target = U_IDLE;
            end
            U_DEC:
            begin
                w.hd_rd  = HR_CPU;
                w.cond   = C_ALLOC;
                w.target = U_ACHK;
            end
            U_FCHK:
            begin
                w.cond   = C_BADFREE;
                w.target = U_BAD;
            end
            U_FPUSH:
            begin
                w.ln_wr       = LW_FREE;
                w.hd_wr       = HW_FREE;
                w.emit        = 1'b1;
                w.emit_status = ST_FREED;
                w.cond        = C_ALWAYS;
                w.target      = U_IDLE;
            end
            U_ACHK:
            begin
                w.alloc_init = 1'b1;
                w.cond       = C_CPUBAD;
                w.target     = U_NONE;
            end
            U_ATEST:
            begin
                w.cond   = C_TOP_VALID;
                w.target = U_POP;
            end
            U_STEST:
            begin
                w.hd_rd  = HR_OTHER;
                w.cond   = C_STEAL_DONE;
                w.target = U_POP;
            end
            U_SSKIP:
            begin
                w.ln_rd  = LR_HEAD;
                w.cond   = C_OTHER_SKIP;
                w.target = U_NEXT;
            end
            U_SMOVE:
            begin
                w.hd_wr      = HW_STEAL;
                w.ln_wr      = LW_STEAL;
                w.steal_push = 1'b1;
                w.cond       = C_ALWAYS;
                w.target     = U_STEST;
            end
            U_POP:
            begin
                w.ln_rd  = LR_TOP;
                w.cond   = C_TOP_EMPTY;
                w.target = U_NONE;
            end
            U_POPW:
            begin
                w.hd_wr       = HW_POP;
                w.emit        = 1'b1;
                w.emit_status = ST_ALLOCATED;
                w.cond        = C_ALWAYS;
                w.target      = U_IDLE;
            end
            U_NEXT:
            begin
                w.other_inc = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = U_STEST;
            end
            U_BAD:
            begin
                w.emit        = 1'b1;
                w.emit_status = ST_BAD;
                w.cond        = C_ALWAYS;
                w.target      = U_IDLE;
            end
            U_NONE:
            begin
                w.emit        = 1'b1;
                w.emit_status = ST_NONE;
                w.cond        = C_ALWAYS;
                w.target      = U_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/pcpa_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_seq
// Microcode sequencer: step counter, control word lookup and
// conditional jumps.
// ----------------------------------------------------------------------------
module pcpa_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire pcpa_pkg::flags_t  flags,
    output pcpa_pkg::ctrl_t        ctrl,
    output logic                   busy
);

    pcpa_pkg::upc_t upc_reg;
    pcpa_pkg::upc_t upc_next;
    logic           take;

    always_comb
    begin
        ctrl = pcpa_pkg::uc_rom(upc_reg);
        busy = (upc_reg != pcpa_pkg::U_IDLE);
    end

    // Evaluate the jump condition of the current step
    always_comb
    begin
        case (ctrl.cond)
            pcpa_pkg::C_NEVER:      take = 1'b0;
            pcpa_pkg::C_ALWAYS:     take = 1'b1;
            pcpa_pkg::C_NOSTART:    take = !start;
            pcpa_pkg::C_ALLOC:      take = flags.alloc;
            pcpa_pkg::C_BADFREE:    take = flags.bad_free;
            pcpa_pkg::C_CPUBAD:     take = flags.cpu_bad;
            pcpa_pkg::C_TOP_VALID:  take = flags.top_valid;
            pcpa_pkg::C_TOP_EMPTY:  take = !flags.top_valid;
            pcpa_pkg::C_STEAL_DONE: take = flags.steal_done;
            pcpa_pkg::C_OTHER_SKIP: take = flags.other_skip;
            default:                take = 1'b1;
        endcase
        upc_next = take ? ctrl.target : upc_reg + pcpa_pkg::UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= pcpa_pkg::U_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/pcpa_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcpa_dp
// Allocator datapath: request and configuration registers, list head
// memory, link memory, refill counters and the result register.
// ----------------------------------------------------------------------------
module pcpa_dp #(
    parameter int CPU_COUNT  = pcpa_pkg::DEF_CPU_COUNT,
    parameter int PAGE_BYTES = pcpa_pkg::DEF_PAGE_BYTES,
    parameter int PAGE_COUNT = pcpa_pkg::DEF_PAGE_COUNT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                load,
    input  wire pcpa_pkg::request_t                  request,
    input  wire logic                                cfg_write,
    input  wire logic [pcpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pcpa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire pcpa_pkg::ctrl_t                     ctrl,
    output pcpa_pkg::flags_t                         flags,
    output logic                                     done,
    output pcpa_pkg::result_t                        result
);

    localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int PN_W  = $clog2(PAGE_COUNT);
    localparam int OFS_W = $clog2(PAGE_BYTES);

    // Configuration
    logic [31:0] region_low_reg;
    logic [31:0] region_high_reg;
    logic [7:0]  steal_limit_reg;

    // Latched request
    logic        cmd_reg;
    logic [2:0]  cpu_reg;
    logic [31:0] addr_reg;

    // Memories
    logic [PN_W-1:0]  head_mem [CPU_COUNT];
    logic [CPU_COUNT-1:0] head_vld_reg;
    logic [PN_W:0]    link_mem [PAGE_COUNT];

    logic [PN_W-1:0]  head_q_page_reg;
    logic             head_q_vld_reg;
    logic [PN_W:0]    link_q_reg;

    // Refill state
    logic             top_vld_reg;
    logic [PN_W-1:0]  top_page_reg;
    logic [PN_W-1:0]  page_reg;
    logic [CPU_W:0]   other_reg;
    logic [7:0]       left_reg;

    logic             done_reg;
    logic [1:0]       status_reg;
    logic [31:0]      raddr_reg;

    logic [CPU_W-1:0] cpu_idx;
    logic [CPU_W-1:0] other_idx;
    logic [CPU_W:0]   cpu_x;
    logic [PN_W-1:0]  addr_pn;
    logic [CPU_W-1:0] hd_raddr;
    logic [CPU_W-1:0] hd_waddr;
    logic [PN_W-1:0]  hd_wpage;
    logic             hd_wvld;
    logic [PN_W-1:0]  ln_raddr;
    logic [PN_W-1:0]  ln_waddr;
    logic [PN_W:0]    ln_wdata;

    always_comb
    begin
        cpu_idx   = CPU_W'(cpu_reg);
        cpu_x     = (CPU_W+1)'(cpu_reg);
        other_idx = other_reg[CPU_W-1:0];
        addr_pn   = PN_W'(addr_reg >> OFS_W);

        flags.alloc      = (cmd_reg == pcpa_pkg::CMD_ALLOC);
        flags.cpu_bad    = (32'(cpu_reg) >= 32'(CPU_COUNT));
        flags.bad_free   = flags.cpu_bad
                         || (addr_reg[OFS_W-1:0] != '0)
                         || (addr_reg < region_low_reg)
                         || (addr_reg >= region_high_reg)
                         || ((addr_reg >> OFS_W) >= 32'(PAGE_COUNT));
        flags.top_valid  = top_vld_reg;
        flags.steal_done = (left_reg == 8'd0) || (other_reg == (CPU_W+1)'(CPU_COUNT));
        flags.other_skip = (other_reg == cpu_x) || !head_q_vld_reg;
    end

    // Address and data selection for the two memories
    always_comb
    begin
        hd_raddr = (ctrl.hd_rd == pcpa_pkg::HR_OTHER) ? other_idx : cpu_idx;
        hd_waddr = (ctrl.hd_wr == pcpa_pkg::HW_STEAL) ? other_idx : cpu_idx;
        if (ctrl.hd_wr == pcpa_pkg::HW_FREE)
        begin
            hd_wpage = addr_pn;
            hd_wvld  = 1'b1;
        end
        else
        begin
            hd_wpage = link_q_reg[PN_W-1:0];
            hd_wvld  = link_q_reg[PN_W];
        end
        ln_raddr = (ctrl.ln_rd == pcpa_pkg::LR_TOP) ? top_page_reg : head_q_page_reg;
        if (ctrl.ln_wr == pcpa_pkg::LW_STEAL)
        begin
            ln_waddr = page_reg;
            ln_wdata = {top_vld_reg, top_page_reg};
        end
        else
        begin
            ln_waddr = addr_pn;
            ln_wdata = {head_q_vld_reg, head_q_page_reg};
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_low_reg  <= pcpa_pkg::RST_REGION_LOW;
            region_high_reg <= pcpa_pkg::RST_REGION_HIGH;
            steal_limit_reg <= pcpa_pkg::RST_STEAL_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pcpa_pkg::REG_REGION_LOW:  region_low_reg  <= cfg_data;
                pcpa_pkg::REG_REGION_HIGH: region_high_reg <= cfg_data;
                pcpa_pkg::REG_STEAL_LIMIT: steal_limit_reg <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg  <= request.command;
            cpu_reg  <= request.cpu_id;
            addr_reg <= request.page_address;
        end
    end

    // Head memory: payload without reset, valid bits cleared by reset
    always_ff @(posedge clk)
    begin
        if (ctrl.hd_wr != pcpa_pkg::HW_NONE)
        begin
            head_mem[hd_waddr] <= hd_wpage;
        end
        if (ctrl.hd_rd != pcpa_pkg::HR_NONE)
        begin
            head_q_page_reg <= head_mem[hd_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg   <= '0;
            head_q_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.hd_wr != pcpa_pkg::HW_NONE)
            begin
                head_vld_reg[hd_waddr] <= hd_wvld;
            end
            if (ctrl.hd_rd != pcpa_pkg::HR_NONE)
            begin
                head_q_vld_reg <= head_vld_reg[hd_raddr];
            end
        end
    end

    // Link memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.ln_wr != pcpa_pkg::LW_NONE)
        begin
            link_mem[ln_waddr] <= ln_wdata;
        end
        if (ctrl.ln_rd != pcpa_pkg::LR_NONE)
        begin
            link_q_reg <= link_mem[ln_raddr];
        end
    end

    // Refill bookkeeping; page_reg holds the page being moved
    always_ff @(posedge clk)
    begin
        if (ctrl.ln_rd == pcpa_pkg::LR_HEAD)
        begin
            page_reg <= head_q_page_reg;
        end
        if (ctrl.alloc_init)
        begin
            top_page_reg <= head_q_page_reg;
        end
        else if (ctrl.steal_push)
        begin
            top_page_reg <= page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_vld_reg <= 1'b0;
            other_reg   <= '0;
            left_reg    <= '0;
        end
        else
        begin
            if (ctrl.alloc_init)
            begin
                top_vld_reg <= head_q_vld_reg;
                other_reg   <= '0;
                left_reg    <= steal_limit_reg;
            end
            else
            begin
                if (ctrl.steal_push)
                begin
                    top_vld_reg <= 1'b1;
                    left_reg    <= left_reg - 8'd1;
                end
                if (ctrl.other_inc)
                begin
                    other_reg <= other_reg + (CPU_W+1)'(1);
                end
            end
        end
    end

    // Result register: one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            status_reg <= ctrl.emit_status;
            raddr_reg  <= (ctrl.emit_status == pcpa_pkg::ST_ALLOCATED)
                        ? (32'(top_page_reg) << OFS_W) : 32'd0;
        end
    end

    always_comb
    begin
        done                  = done_reg;
        result.status         = status_reg;
        result.result_address = raddr_reg;
    end

endmodule
`default_nettype wire

@@ rtl/per_cpu_page_free_list_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Per-CPU LIFO page free lists threaded through a page-indexed link memory,
// with free, allocate and refill-by-stealing driven by a microcode program.
// ----------------------------------------------------------------------------
//
// Issue a request by raising start while busy is low; the request is taken
// at that clock edge. Each request yields exactly one result, shown on
// result for one cycle with done high; there is no back-pressure, so the
// receiver must capture it in that cycle. A free decodes the request, checks
// the address and pushes the page; an allocate that finds a page on its own
// list decodes, checks the CPU, tests the list, reads the link and pops the
// page. When the requester's list is empty, the refill walks the CPUs in
// ascending order and moves pages until the steal limit is spent or every
// CPU is passed; each moved page needs a head read, a link read and a
// combined head/link write, as the link memory has one write port and one
// registered read port. The result strobe is high in the first cycle with
// busy low, and a new request may be issued in that same cycle. Reset
// empties all lists at once (per-CPU valid bits); the link memory needs no
// clearing. Write the configuration registers only while the block is idle.
//
module per_cpu_page_free_list_allocator #(
    parameter int CPU_COUNT  = pcpa_pkg::DEF_CPU_COUNT,
    parameter int PAGE_BYTES = pcpa_pkg::DEF_PAGE_BYTES,
    parameter int PAGE_COUNT = pcpa_pkg::DEF_PAGE_COUNT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire pcpa_pkg::request_t               request,
    output logic                                  done,
    output pcpa_pkg::result_t                     result,
    input  wire logic                             cfg_write,
    input  wire logic [pcpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pcpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pcpa_pkg::ctrl_t  ctrl;
    pcpa_pkg::flags_t flags;
    logic             load;

    // A request is taken only from the idle step
    assign load = start && !busy;

    // Step counter and control store
    pcpa_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // Lists, link memory, counters and result register
    pcpa_dp #(
        .CPU_COUNT  (CPU_COUNT),
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .flags     (flags),
        .done      (done),
        .result    (result)
    );

endmodule
`default_nettype wire

@@ verif/per_cpu_page_free_list_allocator_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator_tb
// Self-checking bench for the per-CPU page free-list allocator. A clocked
// driver issues free and allocate requests and register writes taken from a
// job queue. A shadow allocator predicts each result when its request is
// taken, and a clocked monitor checks every strobed result against the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator_tb;

    localparam int          CPUS          = pcpa_pkg::DEF_CPU_COUNT;
    localparam int          PAGE_BYTES    = pcpa_pkg::DEF_PAGE_BYTES;
    localparam int          PAGES         = pcpa_pkg::DEF_PAGE_COUNT;
    localparam int          IDX_W         = pcpa_pkg::CFG_IDX_W;
    localparam int          DATA_W        = pcpa_pkg::CFG_DATA_W;
    localparam logic [15:0] NO_PAGE       = 16'hFFFF;
    // Every request yields a result and the strobe follows busy, so a short
    // quiet stretch is enough before touching the registers.
    localparam int          SETTLE_CYCLES = 8;
    localparam int          TAIL_CYCLES   = 50;
    // The worst refill moves up to 255 pages; about 550 requests at that worst
    // case, plus the sender gaps, still stay far below this.
    localparam int          CYCLE_LIMIT   = 2_000_000;

    typedef enum logic [1:0] {
        JOB_REQUEST,
        JOB_REG_WRITE,
        JOB_PACE
    } job_kind_t;

    typedef struct {
        job_kind_t          kind;
        pcpa_pkg::request_t req;
        logic               drain_first;
        logic [IDX_W-1:0]   reg_idx;
        logic [DATA_W-1:0]  reg_val;
        int                 idle_pct;
    } job_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    pcpa_pkg::request_t request   = '0;
    logic               done;
    pcpa_pkg::result_t  result;
    logic               cfg_write = 1'b0;
    logic [IDX_W-1:0]   cfg_index = pcpa_pkg::REG_REGION_LOW;
    logic [DATA_W-1:0]  cfg_data  = '0;

    // Shadow allocator: link table, list heads and register copies
    logic [15:0] shadow_link [PAGES];
    logic [15:0] shadow_head [CPUS];
    logic [31:0] shadow_low;
    logic [31:0] shadow_high;
    logic [7:0]  shadow_steal;

    pcpa_pkg::result_t owed_results [$];
    job_t              pending_jobs [$];

    int requests_issued = 0;
    int results_taken   = 0;
    int quiet_cycles    = 0;
    int idle_pct        = 0;
    int error_count     = 0;
    int cycle_count     = 0;

    // Register values the job generator plans with (ahead of the driver)
    logic [31:0] plan_low  = pcpa_pkg::RST_REGION_LOW;
    logic [31:0] plan_high = pcpa_pkg::RST_REGION_HIGH;

    job_t              head_job;
    logic              launch;
    logic              reg_write;
    logic              settled;
    pcpa_pkg::result_t owed;

    per_cpu_page_free_list_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Apply one request to the shadow lists and return the result it earns.
    function automatic pcpa_pkg::result_t serve_request(input pcpa_pkg::request_t r);
        pcpa_pkg::result_t res;
        logic [31:0]       pn;
        int unsigned       budget;
        logic [15:0]       pg;
        res.status         = pcpa_pkg::ST_FREED;
        res.result_address = '0;
        if (r.command == pcpa_pkg::CMD_FREE)
        begin
            pn = r.page_address / PAGE_BYTES;
            // reject misaligned, below floor, at/above ceiling, past table
            if (int'(r.cpu_id) >= CPUS || r.page_address % PAGE_BYTES != 0 ||
                r.page_address < shadow_low || r.page_address >= shadow_high ||
                pn >= PAGES)
                res.status = pcpa_pkg::ST_BAD;
            else
            begin
                shadow_link[pn]         = shadow_head[r.cpu_id];
                shadow_head[r.cpu_id]   = pn[15:0];
            end
        end
        else if (int'(r.cpu_id) >= CPUS)
            res.status = pcpa_pkg::ST_NONE;
        else
        begin
            // Own list empty: pull pages one by one from the other CPUs,
            // lowest index first, until the budget runs out.
            if (shadow_head[r.cpu_id] >= PAGES)
            begin
                budget = 32'(shadow_steal);
                for (int c = 0; c < CPUS && budget != 0; c++)
                begin
                    if (c != int'(r.cpu_id))
                    begin
                        while (budget != 0 && shadow_head[c] < PAGES)
                        begin
                            pg                    = shadow_head[c];
                            shadow_head[c]        = shadow_link[pg];
                            shadow_link[pg]       = shadow_head[r.cpu_id];
                            shadow_head[r.cpu_id] = pg;
                            budget--;
                        end
                    end
                end
            end
            if (shadow_head[r.cpu_id] < PAGES)
            begin
                pg                    = shadow_head[r.cpu_id];
                shadow_head[r.cpu_id] = shadow_link[pg];
                res.status            = pcpa_pkg::ST_ALLOCATED;
                res.result_address    = 32'(pg * PAGE_BYTES);
            end
            else
                res.status = pcpa_pkg::ST_NONE;
        end
        return res;
    endfunction

    // Draw one request against the planned region: mostly good frees and
    // allocates, the rest malformed frees.
    function automatic pcpa_pkg::request_t random_request();
        pcpa_pkg::request_t r;
        longint unsigned    lo_pn;
        longint unsigned    hi_pn;
        longint unsigned    span;
        longint unsigned    win;
        longint unsigned    pn;
        int unsigned        roll;
        roll  = $urandom_range(99);
        lo_pn = 64'(plan_low);
        lo_pn = (lo_pn + PAGE_BYTES - 1) / PAGE_BYTES;
        hi_pn = 64'(plan_high);
        hi_pn = (hi_pn + PAGE_BYTES - 1) / PAGE_BYTES;
        if (hi_pn > PAGES)
            hi_pn = 64'(PAGES);
        // Allocates lean on CPUs 0..3 and frees on 4..7 so refills happen.
        r.command      = pcpa_pkg::CMD_ALLOC;
        r.cpu_id       = 3'($urandom_range(1) ? $urandom_range(3) : $urandom_range(7));
        r.page_address = $urandom();
        if (roll < 50 && lo_pn < hi_pn)
        begin
            span = hi_pn - lo_pn;
            win  = span < 256 ? span : 256;
            case ($urandom_range(5))
                0:       pn = hi_pn - 1 - $urandom_range(32'(win - 1));
                1:       pn = lo_pn + {$urandom(), $urandom()} % span;
                default: pn = lo_pn + $urandom_range(32'(win - 1));
            endcase
            r.command      = pcpa_pkg::CMD_FREE;
            r.cpu_id       = 3'($urandom_range(1) ? 4 + $urandom_range(3)
                                                  : $urandom_range(7));
            r.page_address = 32'(pn * PAGE_BYTES);
        end
        else if (roll >= 85)
        begin
            r.command = pcpa_pkg::CMD_FREE;
            case ($urandom_range(3))
                0:       r.page_address = $urandom();
                // page just under the floor; wraps to the top when floor is 0
                1:       r.page_address = 32'(lo_pn * PAGE_BYTES - PAGE_BYTES);
                // first page at the ceiling or past the table
                2:       r.page_address = 32'(hi_pn * PAGE_BYTES);
                default: r.page_address = 32'((lo_pn + $urandom_range(255)) * PAGE_BYTES
                                              + $urandom_range(PAGE_BYTES - 1, 1));
            endcase
        end
        return r;
    endfunction

    task automatic queue_request(input pcpa_pkg::request_t r, input logic hold);
        job_t j;
        j.kind        = JOB_REQUEST;
        j.req         = r;
        j.drain_first = hold;
        j.reg_idx     = pcpa_pkg::REG_REGION_LOW;
        j.reg_val     = '0;
        j.idle_pct    = 0;
        pending_jobs.push_back(j);
    endtask

    task automatic queue_reg_write(input logic [IDX_W-1:0] idx,
                                   input logic [DATA_W-1:0] val);
        job_t j;
        j.kind        = JOB_REG_WRITE;
        j.req         = '0;
        j.drain_first = 1'b0;
        j.reg_idx     = idx;
        j.reg_val     = val;
        j.idle_pct    = 0;
        pending_jobs.push_back(j);
    endtask

    // One phase: set the sender pace, rewrite every register, then queue
    // random requests drawn against the new region.
    task automatic run_phase(input int pct, input logic [31:0] low,
                             input logic [31:0] high, input logic [31:0] steal,
                             input int count);
        job_t j;
        j.kind        = JOB_PACE;
        j.req         = '0;
        j.drain_first = 1'b0;
        j.reg_idx     = pcpa_pkg::REG_REGION_LOW;
        j.reg_val     = '0;
        j.idle_pct    = pct;
        pending_jobs.push_back(j);
        queue_reg_write(pcpa_pkg::REG_REGION_LOW, low);
        queue_reg_write(pcpa_pkg::REG_REGION_HIGH, high);
        queue_reg_write(pcpa_pkg::REG_STEAL_LIMIT, steal);
        plan_low  = low;
        plan_high = high;
        // now and then hold a request back until the block has drained
        repeat (count)
            queue_request(random_request(), $urandom_range(39) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: take the head job when the request slot is free. Requests go
    // out with start; register writes wait until nothing is in flight and
    // the block has been quiet for a while; pace jobs change the idle rate.
    // Predict each request at the edge that takes it, so the shadow lists
    // advance in the same order as the block's.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start           <= 1'b0;
            request         <= '0;
            cfg_write       <= 1'b0;
            cfg_index       <= pcpa_pkg::REG_REGION_LOW;
            cfg_data        <= '0;
            requests_issued <= 0;
            quiet_cycles    <= 0;
            idle_pct        <= 0;
            foreach (shadow_head[c])
                shadow_head[c] = NO_PAGE;
            shadow_low   = pcpa_pkg::RST_REGION_LOW;
            shadow_high  = pcpa_pkg::RST_REGION_HIGH;
            shadow_steal = pcpa_pkg::RST_STEAL_LIMIT;
        end
        else
        begin
            launch    = 1'b0;
            reg_write = 1'b0;
            if (start && !busy)
            begin
                owed_results.push_back(serve_request(request));
                requests_issued <= requests_issued + 1;
            end
            // results_taken is the pre-edge count, so a result landing on this very
            // edge only delays the drain and never cuts it short
            settled = !start && !busy && requests_issued == results_taken;
            quiet_cycles <= settled ? quiet_cycles + 1 : 0;
            if (!(start && busy) && pending_jobs.size() != 0)
            begin
                head_job = pending_jobs[0];
                case (head_job.kind)
                    JOB_REQUEST:
                    begin
                        if ((!head_job.drain_first || settled) &&
                            $urandom_range(99) >= idle_pct)
                            launch = 1'b1;
                    end
                    JOB_REG_WRITE:
                    begin
                        if (settled && quiet_cycles >= SETTLE_CYCLES)
                        begin
                            reg_write = 1'b1;
                            case (head_job.reg_idx)
                                pcpa_pkg::REG_REGION_LOW:
                                    shadow_low   = head_job.reg_val;
                                pcpa_pkg::REG_REGION_HIGH:
                                    shadow_high  = head_job.reg_val;
                                pcpa_pkg::REG_STEAL_LIMIT:
                                    shadow_steal = head_job.reg_val[7:0];
                                default: ;
                            endcase
                        end
                    end
                    JOB_PACE:
                    begin
                        idle_pct <= head_job.idle_pct;
                    end
                    default:
                    begin
                    end
                endcase
                if (launch || reg_write || head_job.kind == JOB_PACE)
                    void'(pending_jobs.pop_front());
            end
            // hold start through busy; one assignment per edge
            start <= launch || (start && busy);
            if (launch)
                request <= head_job.req;
            cfg_write <= reg_write;
            if (reg_write)
            begin
                cfg_index <= head_job.reg_idx;
                cfg_data  <= head_job.reg_val;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: a result is valid only in its done cycle; check it against
    // the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_taken <= 0;
        else if (done)
        begin
            results_taken <= results_taken + 1;
            if (owed_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d, result_address %h",
                       result.status, result.result_address);
                error_count++;
            end
            else
            begin
                owed = owed_results.pop_front();
                if (result.status !== owed.status)
                begin
                    $error("status: expected %0d, got %0d", owed.status, result.status);
                    error_count++;
                end
                if (result.result_address !== owed.result_address)
                begin
                    $error("result_address: expected %h, got %h",
                           owed.result_address, result.result_address);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed requests under the reset registers, then random
    // phases that each rewrite every register and change the sender pace.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] rand_low;

        // empty everywhere; the address of an allocate is ignored
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_ALLOC, 3'd0, 32'hFFFF_FFFF}, 1'b0);
        // lowest and highest page of the table
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd0, 32'h0000_0000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd7, 32'h07FF_F000}, 1'b0);
        // at the ceiling, far above it, and misaligned
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd1, 32'h0800_0000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd2, 32'hFFFF_F000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd3, 32'h0000_0FFF}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd3, 32'h0000_0800}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_ALLOC, 3'd7, 32'h0000_0000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_ALLOC, 3'd0, 32'h5555_5555}, 1'b0);
        // refill that finds nothing anywhere
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_ALLOC, 3'd5, 32'hAAAA_AAAA}, 1'b0);
        // spread pages over CPUs 1, 4 and 6, then refill CPU 0 from all
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd1, 32'h0000_5000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd1, 32'h0000_6000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd1, 32'h0000_7000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd4, 32'h0000_8000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd6, 32'h0000_9000}, 1'b0);
        // hold this one until every earlier result is in
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_ALLOC, 3'd0, 32'h0000_0000}, 1'b1);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_ALLOC, 3'd0, 32'h0000_0000}, 1'b0);
        // double free of one page, then pop it twice
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd2, 32'h0001_4000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_FREE, 3'd2, 32'h0001_4000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_ALLOC, 3'd2, 32'h0000_0000}, 1'b0);
        queue_request(pcpa_pkg::request_t'{pcpa_pkg::CMD_ALLOC, 3'd2, 32'h0000_0000}, 1'b0);

        // full table, widest refill
        run_phase(0, pcpa_pkg::RST_REGION_LOW, pcpa_pkg::RST_REGION_HIGH, 32'd255, 100);
        // narrow window, one page per refill
        run_phase(65, 32'h0010_0000, 32'h0018_0000, 32'd1, 100);
        // ceiling above the table, no refill at all
        run_phase(29, 32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 100);
        // unaligned floor near the table end; junk in the upper data bits
        run_phase(0, 32'h07FF_8801, 32'h0800_0000, 32'hFFFF_FF02, 90);
        // floor above ceiling: every free is rejected
        run_phase(65, 32'hFFFF_FFFF, 32'h0000_0000, 32'd10, 40);
        rand_low = $urandom_range(PAGES - 1) * PAGE_BYTES +
                   ($urandom_range(1) ? 0 : $urandom_range(PAGE_BYTES - 1));
        run_phase(29, rand_low, rand_low + $urandom_range(32'h0100_0000), $urandom(), 100);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last request and its result, then watch for strays
        do
            @(negedge clk);
        while (pending_jobs.size() != 0 || start || requests_issued != results_taken);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (owed_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", owed_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
